### src/tpr_pkg.sv
// shared types and constants of the text packet receiver
package tpr_pkg;

  localparam int unsigned BUFFER_DEPTH = 128;
  localparam int unsigned PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned IDX_W        = 7;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;

  // command queue between front and back, and the result queue in the back end
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE      = 2'd0,
    CFG_FIRST_END_BYTE  = 2'd1,
    CFG_SECOND_END_BYTE = 2'd2
  } cfg_idx_e;

  localparam byte_t START_BYTE_RST      = 8'h40;
  localparam byte_t FIRST_END_BYTE_RST  = 8'h0d;
  localparam byte_t SECOND_END_BYTE_RST = 8'h0a;
  localparam byte_t TERMINATOR          = 8'h00;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic             packet_ready;
    logic [LEN_W-1:0] packet_length;
    logic [7:0]       read_data;
    logic             overflow;
    logic             receiving;
  } result_t;

  typedef struct packed {
    logic             packet_ready;
    logic [LEN_W-1:0] packet_length;
    logic             overflow;
    logic             receiving;
  } status_t;

  typedef struct packed {
    logic    wr;
    logic    rd;
    ptr_t    addr;
    byte_t   wdata;
    status_t status;
  } cmd_t;

endpackage

### src/text_packet_receiver.sv
// top level of the text packet receiver: framing front, command queue, store back end
//
//   channel   direction  handshake                   payload
//   request   in         push / full                 item_i (op, rx_byte, read_index)
//   result    out        empty / pop                 result_o (status and read data)
//   config    in         cfg_we_i, cfg_idx_i         cfg_data_i (start and end bytes)
//
// one request per cycle sustained while full stays low; its result passes from acceptance through
// the command queue, the ram read stage and the result queue
// framing state updates in the cycle of acceptance, store writes and reads follow in order
// in the back end, so a read always sees every earlier byte
// the payload store has no reset and needs no clearing pass; flags and phase reset at once
// a stalled result side fills the result queue, then the command queue, then raises full
module text_packet_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  tpr_pkg::item_t                item_i,
  output logic                          empty,
  input  logic                          pop,
  output tpr_pkg::result_t              result_o,
  input  logic                          cfg_we_i,
  input  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_data_i
);

  logic          accept;
  tpr_pkg::cmd_t front_cmd, queue_cmd;
  logic          queue_valid, queue_pop;

  // request taken whenever the command queue has room
  assign accept = push && !full;

  tpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (front_cmd)
  );

  // decouples framing from the store so each side stalls on its own
  tpr_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // ram access plus a small result queue on the output side
  tpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

### src/tpr_ram.sv
// generic single port write, single port read ram with registered read
module tpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/tpr_front.sv
// framing state machine: classifies each request and issues a store command
module tpr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  tpr_pkg::item_t                item_i,
  input  logic                          cfg_we_i,
  input  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  output tpr_pkg::cmd_t                 cmd_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_END     = 2'd2;

  tpr_pkg::byte_t start_q, fend_q, send_q;
  logic [1:0]     phase_q, phase_d;
  tpr_pkg::ptr_t  wpos_q, wpos_d;
  logic           ready_q, ready_d;
  logic           ovf_q, ovf_d;
  tpr_pkg::len_t  len_q, len_d;
  logic           in_range;

  assign in_range = (32'(item_i.read_index) < 32'(tpr_pkg::BUFFER_DEPTH));

  always_comb begin
    phase_d = phase_q;
    wpos_d  = wpos_q;
    ready_d = ready_q;
    ovf_d   = ovf_q;
    len_d   = len_q;
    cmd_o   = '0;
    unique case (item_i.op)
      tpr_pkg::OP_BYTE: begin
        unique case (phase_q)
          PH_PAYLOAD: begin
            if (item_i.rx_byte == fend_q) begin
              phase_d = PH_END;
            end else if (wpos_q != tpr_pkg::ptr_t'(tpr_pkg::BUFFER_DEPTH - 1)) begin
              cmd_o.wr    = 1'b1;
              cmd_o.addr  = wpos_q;
              cmd_o.wdata = item_i.rx_byte;
              wpos_d      = wpos_q + tpr_pkg::ptr_t'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          PH_END: begin
            if (item_i.rx_byte == send_q) begin
              cmd_o.wr    = 1'b1;
              cmd_o.addr  = wpos_q;
              cmd_o.wdata = tpr_pkg::TERMINATOR;
              len_d       = tpr_pkg::len_t'(wpos_q);
              ready_d     = 1'b1;
              phase_d     = PH_IDLE;
            end
          end
          default: begin
            if (item_i.rx_byte == start_q && !ready_q) begin
              phase_d = PH_PAYLOAD;
              wpos_d  = '0;
            end
          end
        endcase
      end
      tpr_pkg::OP_CLEAR: begin
        ready_d = 1'b0;
        ovf_d   = 1'b0;
      end
      tpr_pkg::OP_READ: begin
        cmd_o.rd   = in_range;
        cmd_o.addr = tpr_pkg::ptr_t'(item_i.read_index);
      end
      default: ;
    endcase
    cmd_o.status.packet_ready  = ready_d;
    cmd_o.status.packet_length = len_d;
    cmd_o.status.overflow      = ovf_d;
    cmd_o.status.receiving     = (phase_d == PH_PAYLOAD) || (phase_d == PH_END);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wpos_q  <= '0;
      ready_q <= 1'b0;
      ovf_q   <= 1'b0;
      len_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wpos_q  <= wpos_d;
      ready_q <= ready_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= tpr_pkg::START_BYTE_RST;
      fend_q  <= tpr_pkg::FIRST_END_BYTE_RST;
      send_q  <= tpr_pkg::SECOND_END_BYTE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpr_pkg::CFG_START_BYTE:      start_q <= cfg_data_i;
        tpr_pkg::CFG_FIRST_END_BYTE:  fend_q  <= cfg_data_i;
        tpr_pkg::CFG_SECOND_END_BYTE: send_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### src/tpr_cmd_queue.sv
// short command queue between the framing front and the store back end
module tpr_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tpr_pkg::cmd_t cmd_o
);

  tpr_pkg::cmd_t                entry_q [tpr_pkg::Q_DEPTH];
  logic [tpr_pkg::Q_PTR_W-1:0]  wptr_q, rptr_q;
  logic [tpr_pkg::Q_CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == tpr_pkg::Q_CNT_W'(tpr_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == tpr_pkg::Q_PTR_W'(tpr_pkg::Q_DEPTH - 1)) ? '0
                : wptr_q + tpr_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == tpr_pkg::Q_PTR_W'(tpr_pkg::Q_DEPTH - 1)) ? '0
                : rptr_q + tpr_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + tpr_pkg::Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - tpr_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

### src/tpr_back.sv
// store back end: payload ram access and the result queue
module tpr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  tpr_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output tpr_pkg::result_t result_o
);

  tpr_pkg::byte_t              rdata;
  logic                        s1_valid_q, s1_rd_q;
  tpr_pkg::status_t            s1_status_q;
  tpr_pkg::result_t            s1_result;
  tpr_pkg::result_t            entry_q [tpr_pkg::Q_DEPTH];
  logic [tpr_pkg::Q_PTR_W-1:0] wptr_q, rptr_q;
  logic [tpr_pkg::Q_CNT_W-1:0] cnt_q;
  logic [tpr_pkg::Q_CNT_W:0]   occ;
  logic                        issue, pop_fire;

  assign pop_fire = pop_i && !empty_o;
  assign empty_o  = (cnt_q == '0);
  assign result_o = entry_q[rptr_q];

  // results already queued or in flight through the ram stage
  assign occ   = {1'b0, cnt_q} + (tpr_pkg::Q_CNT_W + 1)'(s1_valid_q);
  assign issue = cmd_valid_i &&
                 ((occ < (tpr_pkg::Q_CNT_W + 1)'(tpr_pkg::Q_DEPTH)) ||
                  ((occ == (tpr_pkg::Q_CNT_W + 1)'(tpr_pkg::Q_DEPTH)) && pop_fire));
  assign cmd_pop_o = issue;

  tpr_ram #(
    .WIDTH (tpr_pkg::BYTE_W),
    .DEPTH (tpr_pkg::BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (issue && cmd_i.wr),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.wdata),
    .re_i    (issue && cmd_i.rd),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_result.packet_ready  = s1_status_q.packet_ready;
    s1_result.packet_length = s1_status_q.packet_length;
    s1_result.read_data     = s1_rd_q ? rdata : '0;
    s1_result.overflow      = s1_status_q.overflow;
    s1_result.receiving     = s1_status_q.receiving;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_status_q <= cmd_i.status;
      s1_rd_q     <= cmd_i.rd;
    end
    if (s1_valid_q) begin
      entry_q[wptr_q] <= s1_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= issue;
      if (s1_valid_q) begin
        wptr_q <= (wptr_q == tpr_pkg::Q_PTR_W'(tpr_pkg::Q_DEPTH - 1)) ? '0
                : wptr_q + tpr_pkg::Q_PTR_W'(1);
      end
      if (pop_fire) begin
        rptr_q <= (rptr_q == tpr_pkg::Q_PTR_W'(tpr_pkg::Q_DEPTH - 1)) ? '0
                : rptr_q + tpr_pkg::Q_PTR_W'(1);
      end
      if (s1_valid_q && !pop_fire) begin
        cnt_q <= cnt_q + tpr_pkg::Q_CNT_W'(1);
      end else if (pop_fire && !s1_valid_q) begin
        cnt_q <= cnt_q - tpr_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

### bench/tb_text_packet_receiver.sv
// self-checking testbench of the text packet receiver: directed table, then random framed traffic
`timescale 1ns / 1ps

module tb_text_packet_receiver;

  // op code left unused by the block, still legal on the request bus
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRESSURE_AT = 200;
  localparam int unsigned PRESSURE_HOLD = 120;
  localparam int unsigned PHASE_ITEMS = 115;
  localparam int unsigned NUM_DIRECTED = 25;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_END     = 2'd2
  } frame_phase_e;

  typedef struct packed {
    logic [1:0]                op;
    tpr_pkg::byte_t            rx;
    logic [tpr_pkg::IDX_W-1:0] idx;
    logic                      typed;
    tpr_pkg::result_t          want;
  } dir_row_t;

  // directed requests at the reset settings ('@', CR, LF); typed status only where obvious
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // clear after reset
    '{tpr_pkg::OP_CLEAR, 8'h5a, 7'h00, 1'b1, '{1'b0, 7'd0, 8'h00, 1'b0, 1'b0}},
    // spare op, extremes
    '{OP_SPARE,          8'hff, 7'h7f, 1'b1, '{1'b0, 7'd0, 8'h00, 1'b0, 1'b0}},
    // noise while idle
    '{tpr_pkg::OP_BYTE,  8'h00, 7'h55, 1'b1, '{1'b0, 7'd0, 8'h00, 1'b0, 1'b0}},
    '{tpr_pkg::OP_BYTE,  8'h40, 7'h2a, 1'b1, '{1'b0, 7'd0, 8'h00, 1'b0, 1'b1}}, // start opens
    '{tpr_pkg::OP_BYTE,  8'h40, 7'h00, 1'b0, '0},  // start inside a packet is payload
    '{tpr_pkg::OP_BYTE,  8'hff, 7'h7f, 1'b0, '0},
    '{tpr_pkg::OP_BYTE,  8'h00, 7'h00, 1'b0, '0},
    '{tpr_pkg::OP_BYTE,  8'h0a, 7'h11, 1'b0, '0},  // second end byte before the first is payload
    '{tpr_pkg::OP_BYTE,  8'h0d, 7'h00, 1'b0, '0},  // first end byte
    '{tpr_pkg::OP_BYTE,  8'h55, 7'h00, 1'b0, '0},  // ignored after first end
    '{tpr_pkg::OP_BYTE,  8'h0d, 7'h00, 1'b0, '0},  // repeated first end ignored
    '{tpr_pkg::OP_BYTE,  8'h0a, 7'h00, 1'b1, '{1'b1, 7'd4, 8'h00, 1'b0, 1'b0}}, // packet done
    '{tpr_pkg::OP_BYTE,  8'h40, 7'h00, 1'b0, '0},  // start while ready is ignored
    '{tpr_pkg::OP_READ,  8'h33, 7'd0,  1'b0, '0},
    '{tpr_pkg::OP_READ,  8'h00, 7'd1,  1'b0, '0},
    '{tpr_pkg::OP_READ,  8'hff, 7'd4,  1'b0, '0},  // terminator
    '{OP_SPARE,          8'h00, 7'h00, 1'b0, '0},
    '{tpr_pkg::OP_CLEAR, 8'h00, 7'h00, 1'b0, '0},
    '{tpr_pkg::OP_BYTE,  8'h40, 7'h00, 1'b0, '0},
    '{tpr_pkg::OP_CLEAR, 8'h00, 7'h00, 1'b0, '0},  // clear keeps the open packet going
    '{tpr_pkg::OP_BYTE,  8'h0d, 7'h00, 1'b0, '0},  // empty payload
    '{tpr_pkg::OP_BYTE,  8'h0a, 7'h00, 1'b1, '{1'b1, 7'd0, 8'h00, 1'b0, 1'b0}},
    '{tpr_pkg::OP_READ,  8'h00, 7'd0,  1'b0, '0},
    '{tpr_pkg::OP_READ,  8'h00, 7'd3,  1'b0, '0},  // byte left over from the first packet
    '{tpr_pkg::OP_CLEAR, 8'h00, 7'h00, 1'b1, '{1'b0, 7'd0, 8'h00, 1'b0, 1'b0}}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push;
  logic                          full;
  tpr_pkg::item_t                item_i;
  logic                          empty;
  logic                          pop;
  tpr_pkg::result_t              result_o;
  logic                          cfg_we_i;
  logic [tpr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]                    cfg_data_i;

  text_packet_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // shadow of the framing logic, advanced on every accepted request
  tpr_pkg::byte_t                 cur_start = tpr_pkg::START_BYTE_RST;
  tpr_pkg::byte_t                 cur_end1  = tpr_pkg::FIRST_END_BYTE_RST;
  tpr_pkg::byte_t                 cur_end2  = tpr_pkg::SECOND_END_BYTE_RST;
  frame_phase_e                   fr_phase  = PH_IDLE;
  tpr_pkg::ptr_t                  fr_wpos   = '0;
  logic                           fr_ready  = 1'b0;
  logic                           fr_ovf    = 1'b0;
  tpr_pkg::len_t                  fr_len    = '0;
  tpr_pkg::byte_t                 fr_store [tpr_pkg::BUFFER_DEPTH];
  bit [tpr_pkg::BUFFER_DEPTH-1:0] stored_map = '0;

  tpr_pkg::result_t status_due [$];
  int unsigned      fail_count   = 0;
  int unsigned      results_seen = 0;
  int unsigned      phase_items  = 0;
  int unsigned      quiet_cycles = 0;
  bit               tx_burst     = 1'b0;

  function automatic tpr_pkg::result_t deframe_step(input tpr_pkg::item_t it);
    tpr_pkg::result_t r;
    r = '0;
    case (it.op)
      tpr_pkg::OP_BYTE: begin
        case (fr_phase)
          PH_PAYLOAD: begin
            if (it.rx_byte == cur_end1) begin
              fr_phase = PH_END;
            end else if (int'(fr_wpos) < tpr_pkg::BUFFER_DEPTH - 1) begin
              fr_store[fr_wpos]   = it.rx_byte;
              stored_map[fr_wpos] = 1'b1;
              fr_wpos++;
            end else begin
              // last slot is kept for the terminator
              fr_ovf = 1'b1;
            end
          end
          PH_END: begin
            if (it.rx_byte == cur_end2) begin
              fr_store[fr_wpos]   = tpr_pkg::TERMINATOR;
              stored_map[fr_wpos] = 1'b1;
              fr_len   = tpr_pkg::len_t'(fr_wpos);
              fr_ready = 1'b1;
              fr_phase = PH_IDLE;
            end
          end
          default: begin
            if (it.rx_byte == cur_start && !fr_ready) begin
              fr_phase = PH_PAYLOAD;
              fr_wpos  = '0;
            end
          end
        endcase
      end
      tpr_pkg::OP_CLEAR: begin
        fr_ready = 1'b0;
        fr_ovf   = 1'b0;
      end
      tpr_pkg::OP_READ: r.read_data = fr_store[it.read_index];
      default: ;
    endcase
    r.packet_ready  = fr_ready;
    r.packet_length = fr_len;
    r.overflow      = fr_ovf;
    r.receiving     = (fr_phase != PH_IDLE);
    return r;
  endfunction

  // any store entry already written, so a read never touches an undefined byte
  function automatic logic [tpr_pkg::IDX_W-1:0] pick_stored_index();
    int unsigned base;
    int unsigned k;
    base = $urandom_range(0, tpr_pkg::BUFFER_DEPTH - 1);
    for (int unsigned i = 0; i < tpr_pkg::BUFFER_DEPTH; i++) begin
      k = (base + i) % tpr_pkg::BUFFER_DEPTH;
      if (stored_map[k]) return k[tpr_pkg::IDX_W-1:0];
    end
    return '0;
  endfunction

  task automatic sender_pause();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 60) return;
    n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    @(negedge clk_i);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // offer one request until the block takes it, then log what it must answer
  task automatic send_request(input tpr_pkg::item_t it, input logic typed,
                              input tpr_pkg::result_t want);
    tpr_pkg::result_t predicted;
    @(negedge clk_i);
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    predicted = deframe_step(it);
    status_due.push_back(typed ? want : predicted);
    phase_items++;
    sender_pause();
  endtask

  task automatic send_op(input logic [1:0] op, input tpr_pkg::byte_t rx,
                         input logic [tpr_pkg::IDX_W-1:0] idx);
    tpr_pkg::item_t it;
    it.op         = op;
    it.rx_byte    = rx;
    it.read_index = idx;
    send_request(it, 1'b0, '0);
  endtask

  task automatic send_read(input logic [tpr_pkg::IDX_W-1:0] idx);
    send_op(tpr_pkg::OP_READ, tpr_pkg::byte_t'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_byte(input tpr_pkg::byte_t b);
    send_op(tpr_pkg::OP_BYTE, b,
            tpr_pkg::IDX_W'($urandom_range(0, tpr_pkg::BUFFER_DEPTH - 1)));
  endtask

  // one framed packet with random content, now and then broken or interleaved
  task automatic send_frame(input int unsigned plen);
    tpr_pkg::byte_t b;
    int unsigned    n;
    if (fr_ready && $urandom_range(0, 3) != 0)
      send_op(tpr_pkg::OP_CLEAR, tpr_pkg::byte_t'($urandom), tpr_pkg::IDX_W'($urandom));
    send_byte(cur_start);
    for (int unsigned i = 0; i < plen; i++) begin
      b = tpr_pkg::byte_t'($urandom_range(0, 255));
      if (b == cur_end1 && $urandom_range(0, 15) != 0) b = b ^ 8'h01;
      send_byte(b);
      if ($urandom_range(0, 39) == 0)
        send_op(tpr_pkg::OP_CLEAR, tpr_pkg::byte_t'($urandom), tpr_pkg::IDX_W'($urandom));
    end
    send_byte(cur_end1);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        b = tpr_pkg::byte_t'($urandom_range(0, 255));
        if (b == cur_end2) b = b ^ 8'h80;
        send_byte(b);
      end
    end
    // sometimes the packet is left unfinished
    if ($urandom_range(0, 9) != 0) send_byte(cur_end2);
    n = $urandom_range(0, 3);
    if (n != 0 && stored_map[fr_len]) send_read(fr_len);
    repeat (n) send_read(pick_stored_index());
  endtask

  task automatic send_noise();
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    if (op == tpr_pkg::OP_READ && stored_map == '0) op = tpr_pkg::OP_CLEAR;
    if (op == tpr_pkg::OP_READ) send_read(pick_stored_index());
    else send_op(op, tpr_pkg::byte_t'($urandom_range(0, 255)),
                 tpr_pkg::IDX_W'($urandom_range(0, tpr_pkg::BUFFER_DEPTH - 1)));
  endtask

  // only once every request is answered may the settings change
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input tpr_pkg::cfg_idx_e idx, input tpr_pkg::byte_t v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tpr_pkg::CFG_START_BYTE:     cur_start = v;
      tpr_pkg::CFG_FIRST_END_BYTE: cur_end1  = v;
      default:                     cur_end2  = v;
    endcase
  endtask

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  task automatic check_status(input tpr_pkg::result_t got);
    tpr_pkg::result_t want;
    if (status_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      return;
    end
    want = status_due.pop_front();
    if (got.packet_ready !== want.packet_ready)
      report_field("packet_ready", 8'(want.packet_ready), 8'(got.packet_ready));
    if (got.packet_length !== want.packet_length)
      report_field("packet_length", 8'(want.packet_length), 8'(got.packet_length));
    if (got.read_data !== want.read_data)
      report_field("read_data", want.read_data, got.read_data);
    if (got.overflow !== want.overflow)
      report_field("overflow", 8'(want.overflow), 8'(got.overflow));
    if (got.receiving !== want.receiving)
      report_field("receiving", 8'(want.receiving), 8'(got.receiving));
  endtask

  // result side: random pops with stretches of none, one long hold-off to back up the block
  initial begin
    int unsigned stall_left;
    int unsigned r;
    bit          rx_burst;
    stall_left = 0;
    rx_burst   = 1'b0;
    pop        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        check_status(result_o);
        results_seen++;
        if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        r = $urandom_range(0, 99);
        if (results_seen == PRESSURE_AT) stall_left = PRESSURE_HOLD;
        else if (rx_burst || r < 60) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(8, 30);
      end
    end
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** text_packet_receiver: FAILED **");
    $finish;
  end

  initial begin
    int unsigned    pkt_no;
    int unsigned    plen;
    tpr_pkg::item_t it;
    rst_ni     = 1'b0;
    push       = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = tpr_pkg::CFG_START_BYTE;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_reg(tpr_pkg::CFG_START_BYTE, tpr_pkg::START_BYTE_RST);
          write_reg(tpr_pkg::CFG_FIRST_END_BYTE, tpr_pkg::FIRST_END_BYTE_RST);
          write_reg(tpr_pkg::CFG_SECOND_END_BYTE, tpr_pkg::SECOND_END_BYTE_RST);
        end
        1: begin
          write_reg(tpr_pkg::CFG_START_BYTE, tpr_pkg::byte_t'($urandom_range(0, 255)));
          write_reg(tpr_pkg::CFG_FIRST_END_BYTE, tpr_pkg::byte_t'($urandom_range(0, 255)));
          write_reg(tpr_pkg::CFG_SECOND_END_BYTE, tpr_pkg::byte_t'($urandom_range(0, 255)));
        end
        2: begin
          write_reg(tpr_pkg::CFG_START_BYTE, 8'h00);
          write_reg(tpr_pkg::CFG_FIRST_END_BYTE, 8'hff);
          write_reg(tpr_pkg::CFG_SECOND_END_BYTE, 8'h00);
        end
        default: begin
          write_reg(tpr_pkg::CFG_START_BYTE, 8'hff);
          write_reg(tpr_pkg::CFG_FIRST_END_BYTE, 8'h00);
          write_reg(tpr_pkg::CFG_SECOND_END_BYTE, 8'hff);
        end
      endcase

      if (ph == 0) begin
        foreach (DIRECTED[i]) begin
          it.op         = DIRECTED[i].op;
          it.rx_byte    = DIRECTED[i].rx;
          it.read_index = DIRECTED[i].idx;
          send_request(it, DIRECTED[i].typed, DIRECTED[i].want);
        end
      end

      // mostly well-formed packets, the rest noise and broken sequences
      phase_items = 0;
      pkt_no      = 0;
      while (phase_items < PHASE_ITEMS) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) begin
          // one long packet in the even phases, sized around the store depth so that it usually overflows
          if ((ph % 2 == 0) && pkt_no == 2)
            plen = $urandom_range(tpr_pkg::BUFFER_DEPTH - 1, tpr_pkg::BUFFER_DEPTH + 6);
          else if ($urandom_range(0, 7) == 0) plen = $urandom_range(13, 40);
          else plen = $urandom_range(0, 12);
          send_frame(plen);
          pkt_no++;
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && status_due.size() == 0) begin
      $display("** text_packet_receiver: PASSED **");
    end else begin
      $display("** text_packet_receiver: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
src/tpr_pkg.sv
src/tpr_ram.sv
src/tpr_front.sv
src/tpr_cmd_queue.sv
src/tpr_back.sv
src/text_packet_receiver.sv
bench/tb_text_packet_receiver.sv
